@@ design/pireg_pkg.sv @@
package pireg_pkg;

  // Field widths
  localparam int unsigned AdcW    = 10;
  localparam int unsigned GainW   = 8;
  localparam int unsigned ErrW    = 11;
  localparam int unsigned IntegW  = 17;
  localparam int unsigned AccW    = 27;
  localparam int unsigned DivBits = 8;   // output scale is 1/256

  // APB address width: five registers at 4-byte spacing
  localparam int unsigned AddrW   = 5;
  localparam int unsigned ApbDataW = 32;

  // Stream data widths (padded to whole bytes)
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Register indexes
  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_DEADBAND   = 3'd3,
    REG_OUT_MAX    = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic [AdcW-1:0]  SetpointReset  = 10'd0;
  localparam logic [GainW-1:0] PropGainReset  = 8'd35;
  localparam logic [GainW-1:0] IntegGainReset = 8'd2;
  localparam logic [AdcW-1:0]  DeadbandReset  = 10'd2;
  localparam logic [AdcW-1:0]  OutMaxReset    = 10'd1023;

  // Anti-windup limits of the integrator
  localparam logic signed [IntegW-1:0] IntegLimitPos = 17'sd32000;
  localparam logic signed [IntegW-1:0] IntegLimitNeg = -17'sd32000;

  // Bias that turns an arithmetic shift into truncation toward zero
  localparam logic signed [AccW-1:0] DivBias = AccW'((1 << DivBits) - 1);

  typedef struct packed {
    logic [AdcW-1:0]  setpoint;
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [AdcW-1:0]  deadband;
    logic [AdcW-1:0]  out_max;
  } cfg_t;

  typedef struct packed {
    logic [AdcW-1:0]        drive;
    logic signed [ErrW-1:0] error;
    logic                   saturated;
  } res_t;

endpackage

@@ design/pi_regulator_deadband.sv @@
// PI regulator with deadband and integrator anti-windup.
//
// Input stream: one feedback sample per transaction on s_axis_*; tuser carries
// the clear-saturation flag. Output stream: one result per sample on
// m_axis_* with the drive, the error and the saturation flag.
// Gains, setpoint, deadband and drive limit are set through the APB port; the
// user must do so only while no sample is in flight; the block has no check for it.
//
// A sample passes from the input register to the output register and on to
// m_axis; it waits in the input register while the output register is held.
// Throughput: one sample per cycle while m_axis_tready stays high; the rate
// is set by the integrator/drive state loop. A stalled receiver holds the
// result in the output register; the input register still takes one more
// sample, then s_axis_tready drops. Reset (synchronous, active high) clears
// the integrator, the held drive, the saturation flag and the valid flags
// of both stream registers, and loads the default register values.
module pi_regulator_deadband (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pireg_pkg::InDataW-1:0]        s_axis_tdata,  // [9:0] feedback
  input  logic                                 s_axis_tuser,  // [0] clear_saturation
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pireg_pkg::OutDataW-1:0]       m_axis_tdata,  // [9:0] drive, [20:10] error
  output logic                                 m_axis_tuser,  // [0] saturated
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pireg_pkg::AddrW-1:0]          paddr,
  input  logic [pireg_pkg::ApbDataW-1:0]       pwdata,
  output logic [pireg_pkg::ApbDataW-1:0]       prdata,
  output logic                                 pready
);
  import pireg_pkg::*;

  cfg_t                     cfg;
  res_t                     res;
  logic signed [IntegW-1:0] integral_sum;

  logic                     in_valid;
  logic [AdcW-1:0]          in_feedback;
  logic                     in_clear;
  logic                     advance;
  logic                     s_take;

  res_t                     out_res;
  logic                     out_valid;

  pireg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: a sample moves to the output whenever the output is free or taken
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_feedback <= s_axis_tdata[AdcW-1:0];
      in_clear    <= s_axis_tuser;
    end
  end

  pireg_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .cfg              (cfg),
    .feedback         (in_feedback),
    .clear_saturation (in_clear),
    .res              (res),
    .integral_sum     (integral_sum)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataW - AdcW - ErrW){1'b0}}, out_res.error, out_res.drive};
  assign m_axis_tuser  = out_res.saturated;

  // A held sample goes to an empty output register on the next edge
  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("pending sample not moved to output");

  // Integrator stays inside its bounded range
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (integral_sum >= -17'sd33023) && (integral_sum <= 17'sd33022))
    else $error("integrator out of range");

  // An empty input register always accepts
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled while empty");

endmodule

@@ design/pireg_cfg.sv @@
module pireg_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pireg_pkg::AddrW-1:0]       paddr,
  input  logic [pireg_pkg::ApbDataW-1:0]    pwdata,
  output logic [pireg_pkg::ApbDataW-1:0]    prdata,
  output logic                              pready,
  output pireg_pkg::cfg_t                   cfg
);
  import pireg_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= SetpointReset;
      cfg.prop_gain  <= PropGainReset;
      cfg.integ_gain <= IntegGainReset;
      cfg.deadband   <= DeadbandReset;
      cfg.out_max    <= OutMaxReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETPOINT:   cfg.setpoint   <= pwdata[AdcW-1:0];
        REG_PROP_GAIN:  cfg.prop_gain  <= pwdata[GainW-1:0];
        REG_INTEG_GAIN: cfg.integ_gain <= pwdata[GainW-1:0];
        REG_DEADBAND:   cfg.deadband   <= pwdata[AdcW-1:0];
        REG_OUT_MAX:    cfg.out_max    <= pwdata[AdcW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      REG_SETPOINT:   prdata = ApbDataW'(cfg.setpoint);
      REG_PROP_GAIN:  prdata = ApbDataW'(cfg.prop_gain);
      REG_INTEG_GAIN: prdata = ApbDataW'(cfg.integ_gain);
      REG_DEADBAND:   prdata = ApbDataW'(cfg.deadband);
      REG_OUT_MAX:    prdata = ApbDataW'(cfg.out_max);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ design/pireg_core.sv @@
module pireg_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  pireg_pkg::cfg_t             cfg,
  input  logic [pireg_pkg::AdcW-1:0]  feedback,
  input  logic                        clear_saturation,
  output pireg_pkg::res_t             res,
  output logic signed [pireg_pkg::IntegW-1:0] integral_sum
);
  import pireg_pkg::*;

  logic [AdcW-1:0]          held_output;
  logic                     sat_flag;

  logic signed [ErrW-1:0]   err;
  logic [ErrW-1:0]          err_mag;
  logic                     outside;
  logic                     err_pos;
  logic                     sat_eff;
  logic                     integ_add;
  logic signed [IntegW-1:0] integ_next;
  logic signed [AccW-1:0]   acc;
  logic signed [AccW-1:0]   acc_adj;
  logic signed [AccW-1:0]   drv;
  logic signed [AccW-1:0]   max_s;
  logic [AdcW-1:0]          held_next;
  logic                     sat_next;

  // Error and deadband test
  assign err     = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, feedback});
  assign err_mag = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
  assign outside = err_mag > {1'b0, cfg.deadband};
  assign err_pos = !err[ErrW-1] && (err != '0);
  assign sat_eff = sat_flag && !clear_saturation;

  // Integrator with anti-windup limits, frozen while saturated or inside the deadband
  assign integ_add = !sat_eff &&
                     ((err_pos && (integral_sum < IntegLimitPos)) ||
                      (!err_pos && (integral_sum > IntegLimitNeg)));
  assign integ_next = (outside && integ_add) ? integral_sum + IntegW'(err) : integral_sum;

  // Multiply-add, divide by 256 truncating toward zero
  assign acc = AccW'(err) * AccW'($signed({1'b0, cfg.prop_gain})) +
               AccW'(integ_next) * AccW'($signed({1'b0, cfg.integ_gain}));
  assign acc_adj = acc[AccW-1] ? acc + DivBias : acc;
  assign drv     = acc_adj >>> DivBits;
  assign max_s   = $signed(AccW'(cfg.out_max));

  // Clamp and saturation
  always_comb begin
    held_next = held_output;
    sat_next  = sat_eff;
    if (outside) begin
      if (drv > max_s) begin
        held_next = cfg.out_max;
        sat_next  = 1'b1;
      end else if (drv[AccW-1]) begin
        held_next = '0;
        sat_next  = 1'b1;
      end else begin
        held_next = drv[AdcW-1:0];
        sat_next  = 1'b0;
      end
    end
  end

  // Regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      held_output  <= '0;
      sat_flag     <= 1'b0;
    end else if (step) begin
      integral_sum <= integ_next;
      held_output  <= held_next;
      sat_flag     <= sat_next;
    end
  end

  assign res.drive     = held_next;
  assign res.error     = err;
  assign res.saturated = sat_next;

endmodule
